// ===== sv/cqp_pkg.sv =====
// shared widths, codes and types for the circular queue with peek
`timescale 1ns / 1ps
`default_nettype none

package cqp_pkg;

  localparam int CMD_W    = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  localparam int DEFAULT_DEPTH = 8;

  localparam logic [COUNT_W-1:0] CAP_RESET = 4'd8;

  // command codes; the unused code acts as report only
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // front and rear read as this word when the queue is empty
  localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

  // outcome of one operation, from the pointer control to the result stage
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    logic                fwd_front;
    logic                fwd_rear;
  } access_t;

endpackage

`default_nettype wire

// ===== sv/cqp_if.sv =====
// command and result channel interfaces of the circular queue with peek
`timescale 1ns / 1ps
`default_nettype none

interface cqp_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [cqp_pkg::CMD_W-1:0]           cmd;
  logic signed [cqp_pkg::WORD_W-1:0]   push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cqp_res_if;
  logic                                valid;
  logic                                ready;
  logic [cqp_pkg::STATUS_W-1:0]        status;
  logic [cqp_pkg::COUNT_W-1:0]         occupancy;
  logic signed [cqp_pkg::WORD_W-1:0]   front_value;
  logic signed [cqp_pkg::WORD_W-1:0]   rear_value;

  modport source (output valid, output status, output occupancy,
                  output front_value, output rear_value, input ready);
  modport sink   (input valid, input status, input occupancy,
                  input front_value, input rear_value, output ready);
endinterface

`default_nettype wire

// ===== sv/circular_queue_with_peek_unit.sv =====
// Circular queue of signed 32-bit words with a view of its front and rear.
//
// Channels: req carries a transaction with cmd (push, pop, report) and
// push_value; rsp returns one transaction per request with status,
// occupancy, front_value and rear_value after the operation. Front and
// rear read all ones when the queue is empty. cfg_we with cfg_wdata sets
// the ring size (zero acts as one, larger than DEPTH acts as DEPTH) and
// empties the queue; write it only while no request is in flight.
//
// A result passes through the slot memory read register and then the output
// register before rsp.valid rises for it.
// Throughput: one request per cycle while rsp does not stall, since pointers and
// count update in the accept cycle and the memory is read and written then.
//
// Reset (rst, synchronous) empties the queue and sets the ring size to 8;
// the slot memory is not cleared. When rsp stalls the result holds, one
// more request fills the read stage, and then req.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module circular_queue_with_peek_unit #(
  parameter int DEPTH = cqp_pkg::DEFAULT_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst,
  cqp_cmd_if.sink                      req,
  cqp_res_if.source                    rsp,
  input  wire                          cfg_we,
  input  wire  [cqp_pkg::COUNT_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(DEPTH);

  logic                        accept;
  logic                        advance;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr_front;
  logic [AW-1:0]               rd_addr_rear;
  cqp_pkg::access_t            info;
  logic [cqp_pkg::WORD_W-1:0]  rd_front;
  logic [cqp_pkg::WORD_W-1:0]  rd_rear;

  // read stage registers
  logic                        s1_valid;
  cqp_pkg::access_t            s1_info;
  logic [cqp_pkg::WORD_W-1:0]  s1_value;

  // output register
  logic                          out_valid;
  logic [cqp_pkg::STATUS_W-1:0]  out_status;
  logic [cqp_pkg::COUNT_W-1:0]   out_count;
  logic [cqp_pkg::WORD_W-1:0]    out_front;
  logic [cqp_pkg::WORD_W-1:0]    out_rear;

  // handshake
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;

  cqp_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (req.cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .rd_addr_front (rd_addr_front),
    .rd_addr_rear  (rd_addr_rear),
    .info          (info)
  );

  cqp_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (req.push_value),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_front),
    .rd_addr_b (rd_addr_rear),
    .rd_data_a (rd_front),
    .rd_data_b (rd_rear)
  );

  // read stage: operation outcome and pushed word wait for the memory data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info  <= info;
      s1_value <= req.push_value;
    end
  end

  // output register with empty substitution and write forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= s1_info.status;
      out_count  <= s1_info.count;
      out_front  <= s1_info.empty     ? cqp_pkg::EMPTY_WORD :
                    s1_info.fwd_front ? s1_value : rd_front;
      out_rear   <= s1_info.empty     ? cqp_pkg::EMPTY_WORD :
                    s1_info.fwd_rear  ? s1_value : rd_rear;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.occupancy   = out_count;
  assign rsp.front_value = out_front;
  assign rsp.rear_value  = out_rear;

  // checks
  a_empty_reads_ones: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.occupancy == '0) |->
      (rsp.front_value == cqp_pkg::EMPTY_WORD) && (rsp.rear_value == cqp_pkg::EMPTY_WORD))
    else $error("empty queue result does not read all ones");

  a_overflow_not_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == cqp_pkg::ST_OVERFLOW) |-> (rsp.occupancy != '0))
    else $error("overflow reported with an empty queue");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction lost from read stage");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_info))
    else $error("read stage changed while stalled");

endmodule

`default_nettype wire

// ===== sv/cqp_ram.sv =====
// slot memory: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module cqp_ram #(
  parameter int DEPTH = cqp_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [AW-1:0]                wr_addr,
  input  wire  [cqp_pkg::WORD_W-1:0]   wr_data,
  input  wire                          rd_en,
  input  wire  [AW-1:0]                rd_addr_a,
  input  wire  [AW-1:0]                rd_addr_b,
  output logic [cqp_pkg::WORD_W-1:0]   rd_data_a,
  output logic [cqp_pkg::WORD_W-1:0]   rd_data_b
);

  logic [cqp_pkg::WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, data held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cqp_ctrl.sv =====
// ring pointers, entry count and capacity register of the queue
`timescale 1ns / 1ps
`default_nettype none

module cqp_ctrl #(
  parameter int DEPTH = cqp_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           accept,
  input  wire  [cqp_pkg::CMD_W-1:0]     cmd,
  input  wire                           cfg_we,
  input  wire  [cqp_pkg::COUNT_W-1:0]   cfg_wdata,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [AW-1:0]                 rd_addr_front,
  output logic [AW-1:0]                 rd_addr_rear,
  output cqp_pkg::access_t              info
);

  localparam int CW = cqp_pkg::COUNT_W;
  localparam int IW = (AW > CW) ? AW : CW;

  logic [AW-1:0] head, tail;
  logic [CW-1:0] count;
  logic [CW-1:0] capacity;

  logic [CW-1:0] cap_eff;
  logic [AW-1:0] head_use, tail_use;
  logic [CW-1:0] count_use;
  logic [AW-1:0] head_next, tail_next;
  logic [CW-1:0] count_next;
  logic [cqp_pkg::STATUS_W-1:0] status;
  logic [IW-1:0] head_inc, tail_inc;

  // effective ring size: zero acts as one, clipped to the built depth
  always_comb begin
    cap_eff = (capacity == '0) ? CW'(1) : capacity;
    if (int'(cap_eff) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end
  end

  // operation on the pointers
  always_comb begin
    head_use  = (IW'(head) >= IW'(cap_eff)) ? '0 : head;
    tail_use  = (IW'(tail) >= IW'(cap_eff)) ? '0 : tail;
    count_use = (count > cap_eff) ? cap_eff : count;
    head_inc  = IW'(head_use) + IW'(1);
    tail_inc  = IW'(tail_use) + IW'(1);

    head_next  = head_use;
    tail_next  = tail_use;
    count_next = count_use;
    status     = cqp_pkg::ST_OK;
    wr_en      = 1'b0;

    case (cmd)
      cqp_pkg::CMD_PUSH: begin
        if (count_use >= cap_eff) begin
          status = cqp_pkg::ST_OVERFLOW;
        end else begin
          wr_en      = accept;
          tail_next  = (tail_inc >= IW'(cap_eff)) ? '0 : AW'(tail_inc);
          count_next = count_use + CW'(1);
        end
      end
      cqp_pkg::CMD_POP: begin
        if (count_use == '0) begin
          status = cqp_pkg::ST_UNDERFLOW;
        end else begin
          head_next  = (head_inc >= IW'(cap_eff)) ? '0 : AW'(head_inc);
          count_next = count_use - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // addresses of the front and rear entries after the operation
  always_comb begin
    wr_addr       = tail_use;
    rd_addr_front = head_next;
    rd_addr_rear  = (tail_next == '0) ? AW'(cap_eff - CW'(1)) : tail_next - AW'(1);

    info.status    = status;
    info.count     = count_next;
    info.empty     = (count_next == '0);
    // the slot being written is read in the same cycle: take the pushed word
    info.fwd_front = wr_en && (head_next == tail_use);
    info.fwd_rear  = wr_en;
  end

  // state registers; a capacity write empties the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= cqp_pkg::CAP_RESET;
    end else if (cfg_we) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= cfg_wdata;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== bench/cqp_tb_pkg.sv =====
// shadow of the ring queue that predicts and checks each result transaction
`timescale 1ns / 1ps

package cqp_tb_pkg;

  import cqp_pkg::*;

  // what one result transaction should carry
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  occupancy;
    logic [WORD_W-1:0]   front;
    logic [WORD_W-1:0]   rear;
  } queue_view_t;

  class ring_shadow;
    logic [WORD_W-1:0]  slot_word [DEFAULT_DEPTH];
    int unsigned        head;
    int unsigned        tail;
    int unsigned        held;
    logic [COUNT_W-1:0] ring_size;
    queue_view_t        pending_views [$];
    int unsigned        mismatches;

    function new();
      ring_size   = CAP_RESET;
      mismatches  = 0;
      empty_ring();
    endfunction

    function void empty_ring();
      head = 0;
      tail = 0;
      held = 0;
    endfunction

    // a size write also drops everything held
    function void write_ring_size(logic [COUNT_W-1:0] value);
      ring_size = value;
      empty_ring();
    endfunction

    // zero acts as one, anything past the built depth acts as the depth
    function int unsigned active_size();
      if (ring_size == 0) return 1;
      if (ring_size > DEFAULT_DEPTH) return DEFAULT_DEPTH;
      return ring_size;
    endfunction

    function int unsigned wrap_next(int unsigned idx, int unsigned size);
      return (idx + 1 >= size) ? 0 : idx + 1;
    endfunction

    // apply one accepted command and queue the view it should produce
    function void note_request(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] value);
      queue_view_t view;
      int unsigned size;
      int unsigned last;
      size        = active_size();
      view.status = ST_OK;
      view.front  = EMPTY_WORD;
      view.rear   = EMPTY_WORD;
      case (cmd)
        CMD_PUSH: begin
          if (held >= size) begin
            view.status = ST_OVERFLOW;
          end else begin
            slot_word[tail] = value;
            tail = wrap_next(tail, size);
            held++;
          end
        end
        CMD_POP: begin
          if (held == 0) begin
            view.status = ST_UNDERFLOW;
          end else begin
            head = wrap_next(head, size);
            held--;
          end
        end
        default: begin
        end
      endcase
      if (held != 0) begin
        last       = (tail == 0) ? size - 1 : tail - 1;
        view.front = slot_word[head];
        view.rear  = slot_word[last];
      end
      view.occupancy = COUNT_W'(held);
      pending_views.push_back(view);
    endfunction

    task report(string msg);
      if (mismatches < 200) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // compare one result transaction against the oldest pending view
    task check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] occupancy,
                      logic [WORD_W-1:0] front, logic [WORD_W-1:0] rear);
      queue_view_t want;
      string       bad;
      if (pending_views.size() == 0) begin
        report($sformatf("unexpected result status=%0d occupancy=%0d front=%h rear=%h",
                         status, occupancy, front, rear));
        return;
      end
      want = pending_views.pop_front();
      bad  = "";
      if (status !== want.status)
        bad = {bad, $sformatf(" status got %0d want %0d", status, want.status)};
      if (occupancy !== want.occupancy)
        bad = {bad, $sformatf(" occupancy got %0d want %0d", occupancy, want.occupancy)};
      if (front !== want.front)
        bad = {bad, $sformatf(" front got %h want %h", front, want.front)};
      if (rear !== want.rear)
        bad = {bad, $sformatf(" rear got %h want %h", rear, want.rear)};
      if (bad != "") report({"result", bad});
    endtask
  endclass

endpackage

// ===== bench/circular_queue_with_peek_unit_tb.sv =====
// testbench top for the circular queue with peek: stimulus, idling and checking
`timescale 1ns / 1ps

module circular_queue_with_peek_unit_tb;

  import cqp_pkg::*;
  import cqp_tb_pkg::*;

  // spare command code, expected to behave as report only
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 180;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 4;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  int unsigned        idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        quiet_cycles = 0;
  ring_shadow         sb;

  cqp_cmd_if req_if ();
  cqp_res_if rsp_if ();

  circular_queue_with_peek_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // check every result transaction
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.status, rsp_if.occupancy, rsp_if.front_value,
                      rsp_if.rear_value);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // drive one request transaction; entered and left at a falling edge
  task send(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= cmd;
    req_if.push_value <= value;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(cmd, value);
    @(negedge clk);
  endtask

  task wait_drain();
    while (sb.pending_views.size() != 0) @(posedge clk);
  endtask

  // size change only once the queue has gone quiet
  task write_ring_size(input logic [COUNT_W-1:0] value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_ring_size(value);
  endtask

  // word with a bias toward the extremes
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // empty queue cases, extreme words, fill to overflow, drain to underflow
  task run_directed();
    send(CMD_POP, 32'h1234_5678);
    send(CMD_REPORT, 32'h0);
    send(CMD_UNUSED, 32'hFFFF_FFFF);
    send(CMD_PUSH, 32'h8000_0000);
    send(CMD_PUSH, 32'h7FFF_FFFF);
    send(CMD_PUSH, 32'hFFFF_FFFF);
    send(CMD_PUSH, 32'h0000_0000);
    for (int i = 1; i <= 4; i++) send(CMD_PUSH, i);
    send(CMD_PUSH, 32'h5555_5555);
    send(CMD_REPORT, 32'h0);
    send(CMD_UNUSED, 32'h0);
    repeat (8) send(CMD_POP, 32'hAAAA_AAAA);
    send(CMD_POP, 32'h0);
    req_if.valid <= 1'b0;
  endtask

  // bursts that lean toward filling or draining, with some report commands
  task run_random(input int count);
    int unsigned burst_left;
    int unsigned push_pct;
    int unsigned roll;
    logic [CMD_W-1:0] cmd;
    burst_left = 0;
    push_pct   = 50;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(4, 24);
        push_pct   = $urandom_range(1) ? 75 : 25;
      end
      burst_left--;
      roll = $urandom_range(99);
      if (roll < 4)
        cmd = CMD_REPORT;
      else if (roll < 8)
        cmd = CMD_UNUSED;
      else if ($urandom_range(99) < push_pct)
        cmd = CMD_PUSH;
      else
        cmd = CMD_POP;
      send(cmd, random_word());
    end
    req_if.valid <= 1'b0;
  endtask

  function automatic logic [COUNT_W-1:0] phase_ring_size(input int phase);
    case (phase)
      0:       return 4'd1;
      1:       return 4'd0;
      2:       return 4'd15;
      3:       return 4'd8;
      4:       return 4'd3;
      5:       return 4'd9;
      6:       return 4'd2;
      default: return 4'd5;
    endcase
  endfunction

  // main sequence
  initial begin
    sb                = new();
    cfg_we            = 1'b0;
    cfg_wdata         = CAP_RESET;
    req_if.valid      = 1'b0;
    req_if.cmd        = CMD_REPORT;
    req_if.push_value = '0;
    rsp_if.ready      = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_ring_size(phase_ring_size(phase));
      // no idling, sender idle, receiver stalling, both lightly
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      run_random(PHASE_ITEMS);
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
